>>> rtl/core/vmpc_pkg.sv
package vmpc_pkg;

	localparam int TableEntriesDef = 128;
	localparam int PortsDef        = 16;
	localparam int VlansDef        = 4096;

	localparam int VidW  = 12;
	localparam int MacW  = 48;
	localparam int PortW = 4;

	localparam logic [VidW-1:0]  UntaggedVid   = 12'hfff;
	localparam logic [MacW-1:0]  DefaultMarker = 48'h0100_0000_0000;
	localparam logic [15:0]      TpidVlan      = 16'h8100;

	typedef enum logic [1:0] {
		OP_CLASSIFY = 2'd0,
		OP_REGISTER = 2'd1,
		OP_CLEAR    = 2'd2,
		OP_NONE     = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		ST_FORWARD    = 3'd0,
		ST_DROP       = 3'd1,
		ST_REGISTERED = 3'd2,
		ST_FULL       = 3'd3,
		ST_CLEARED    = 3'd4
	} status_t;

	typedef enum logic [3:0] {
		FS_IDLE,
		FS_VRD,
		FS_VCHK,
		FS_SCAN,
		FS_SCANWAIT,
		FS_DECIDE,
		FS_FLOOD,
		FS_VWR,
		FS_CLEAR
	} fsm_t;

endpackage

>>> rtl/core/vlan_mac_port_classifier.sv
// Classify reads the VLAN and untagged words, scans the table in order up to a hit or
// the fill count and gives its result from FS_DECIDE; register scans likewise and then
// writes, but skips the scan when only the VLAN word changes. A flood gives one result
// per cycle. Clear zeroes the fill count and VLAN memory. One transaction at a time.
// Reset: control state and fill count clear at once; the VLAN memory is then swept to
// zero with busy high. Results last one cycle on strobe; no stall.
module vlan_mac_port_classifier
	import vmpc_pkg::*;
#(
	parameter int TABLE_ENTRIES = TableEntriesDef,
	parameter int PORTS         = PortsDef,
	parameter int VLANS         = VlansDef
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  op,
	input  logic [15:0] eth_type,
	input  logic [15:0] tag_ctrl,
	input  logic [47:0] dest_mac,
	input  logic [3:0]  port_index,
	input  logic [11:0] entry_vid,
	input  logic [47:0] entry_mac,
	output logic        strobe,
	output logic [3:0]  out_port,
	output logic [2:0]  status,
	output logic        flooded,
	output logic        last
);
	localparam int EAW = $clog2(TABLE_ENTRIES);
	localparam int VAW = $clog2(VLANS);
	localparam int KeyW = VidW + MacW;
	localparam int VW = 21; // {default valid, default port, members}

	fsm_t state_q, state_d;

	// Captured transaction
	op_t             op_q;
	logic [VidW-1:0] vid_q;
	logic [MacW-1:0] mac_q;
	logic [3:0]      port_q;
	logic            tagged_q;

	// Table: keys/ports in RAM, filled in order up to the fill count count_q
	logic [EAW:0]    count_q;
	logic [EAW:0]    idx_q;
	logic            hit_q;
	logic [EAW-1:0]  hit_idx_q;
	logic [3:0]      hit_port_q;

	// VLAN memory word: [20] default valid, [19:16] default port, [15:0] members
	logic            v_we;
	logic [VAW-1:0]  v_waddr, v_raddr;
	logic [VW-1:0]   v_wdata, v_rdata;
	logic [VW-1:0]   vword_q, gword_q;
	logic            rd_g_q;   // second read (untagged word) in flight

	logic            e_we;
	logic [EAW-1:0]  e_waddr, e_raddr;
	logic [KeyW+3:0] e_wdata, e_rdata;
	logic            scan_vld_s1;
	logic [EAW-1:0]  scan_idx_s1;

	logic [VAW:0]    clr_q;
	logic [4:0]      fl_q;      // flood port pointer (0..17)
	logic            flood_gdef_q;

	vmpc_ram #(.Width(VW), .Depth(VLANS)) u_vlan (
		.clk, .we(v_we), .waddr(v_waddr), .wdata(v_wdata),
		.raddr(v_raddr), .rdata(v_rdata)
	);
	vmpc_ram #(.Width(KeyW + 4), .Depth(TABLE_ENTRIES)) u_tab (
		.clk, .we(e_we), .waddr(e_waddr), .wdata(e_wdata),
		.raddr(e_raddr), .rdata(e_rdata)
	);

	logic [KeyW-1:0] key;
	assign key = {vid_q, mac_q};

	// VID of the transaction on the input ports, read while it is accepted
	logic [VidW-1:0] in_vid;
	assign in_vid = (op_t'(op) != OP_CLASSIFY) ? entry_vid :
		(eth_type == TpidVlan) ? tag_ctrl[11:0] : UntaggedVid;

	logic scan_done;
	assign scan_done = (idx_q >= count_q);

	logic reg_ok;
	assign reg_ok = (mac_q != '0) && ({28'd0, port_q} < PORTS);

	// members restricted to configured ports
	logic [15:0] pmask;
	always_comb begin
		for (int i = 0; i < 16; i++) begin
			pmask[i] = (i < PORTS);
		end
	end

	logic [15:0] mem_m;
	assign mem_m = vword_q[15:0] & pmask;

	// Next pending flood port at or above fl_q
	logic [4:0] fl_next;
	logic       fl_any;
	always_comb begin
		fl_next = 5'd16;
		fl_any  = 1'b0;
		for (int i = 15; i >= 0; i--) begin
			if (mem_m[i] && (i >= fl_q)) begin
				fl_next = 5'(i);
				fl_any  = 1'b1;
			end
		end
	end
	// anything after fl_next?
	logic fl_more;
	always_comb begin
		fl_more = 1'b0;
		for (int i = 0; i < 16; i++) begin
			if (mem_m[i] && (i > fl_next)) begin
				fl_more = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= FS_CLEAR;
			count_q <= '0;
			clr_q   <= '0;
			idx_q   <= '0;
			hit_q   <= 1'b0;
			fl_q    <= '0;
			rd_g_q  <= 1'b0;
			scan_vld_s1 <= 1'b0;
			op_q    <= OP_NONE;
		end else begin
			state_q     <= state_d;
			scan_vld_s1 <= 1'b0;
			rd_g_q      <= 1'b0;
			case (state_q)
				FS_IDLE: begin
					if (start) begin
						op_q  <= op_t'(op);
						idx_q <= '0;
						hit_q <= 1'b0;
						fl_q  <= '0;
						clr_q <= '0;
						if (op_t'(op) == OP_CLEAR) begin
							count_q <= '0;
						end
					end
				end
				FS_VRD: rd_g_q <= 1'b1;
				FS_VCHK: begin
					idx_q <= '0;
				end
				FS_SCAN: begin
					if (!scan_done && !hit_q) begin
						scan_vld_s1 <= 1'b1;
						scan_idx_s1 <= idx_q[EAW-1:0];
						idx_q       <= idx_q + 1'b1;
					end
				end
				FS_FLOOD: fl_q <= fl_next + 5'd1;
				FS_VWR: begin
					if (op_q == OP_REGISTER && reg_ok && mac_q != DefaultMarker && !hit_q
						&& count_q < TABLE_ENTRIES) begin
						count_q <= count_q + 1'b1;
					end
				end
				FS_CLEAR: clr_q <= clr_q + 1'b1;
				default: ;
			endcase
			if (scan_vld_s1 && e_rdata[KeyW+3:4] == key) begin
				hit_q      <= 1'b1;
				hit_idx_q  <= scan_idx_s1;
				hit_port_q <= e_rdata[3:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == FS_IDLE && start && !busy) begin
			if (op_t'(op) == OP_CLASSIFY) begin
				vid_q <= (eth_type == TpidVlan) ? tag_ctrl[11:0] : UntaggedVid;
				mac_q <= dest_mac;
			end else begin
				vid_q <= entry_vid;
				mac_q <= entry_mac;
			end
			tagged_q <= (eth_type == TpidVlan) && (tag_ctrl[11:0] != UntaggedVid);
			port_q   <= port_index;
		end
		if (state_q == FS_VRD) begin
			vword_q <= v_rdata;
		end
		if (rd_g_q) begin
			gword_q <= v_rdata;
		end
		if (state_q == FS_DECIDE) begin
			flood_gdef_q <= gword_q[20] && tagged_q && !(&mem_m);
		end
	end

	always_comb begin
		state_d  = state_q;
		busy     = (state_q != FS_IDLE);
		strobe   = 1'b0;
		out_port = '0;
		status   = ST_FORWARD;
		flooded  = 1'b0;
		last     = 1'b0;
		v_raddr  = vid_q;
		v_we     = 1'b0;
		v_waddr  = vid_q;
		v_wdata  = vword_q;
		e_raddr  = idx_q[EAW-1:0];
		e_we     = 1'b0;
		e_waddr  = count_q[EAW-1:0];
		e_wdata  = {key, port_q};
		case (state_q)
			FS_IDLE: begin
				// VLAN word of the incoming transaction is read at the accepting edge
				v_raddr = in_vid;
				if (start) begin
					case (op_t'(op))
						OP_CLASSIFY, OP_REGISTER: state_d = FS_VRD;
						OP_CLEAR: state_d = FS_CLEAR;
						default: state_d = FS_IDLE;
					endcase
				end
			end
			FS_VRD: begin
				v_raddr = UntaggedVid;
				state_d = FS_VCHK;
			end
			FS_VCHK: begin
				// untagged word lands this cycle into gword_q
				if (op_q == OP_REGISTER && (!reg_ok || mac_q == DefaultMarker)) begin
					state_d = FS_VWR;
				end else begin
					state_d = FS_SCAN;
				end
			end
			FS_SCAN: begin
				if ((scan_done || hit_q) && !scan_vld_s1) begin
					state_d = FS_DECIDE;
				end
			end
			FS_DECIDE: begin
				if (op_q == OP_REGISTER) begin
					state_d = FS_VWR;
				end else if (vword_q[15:0] == '0) begin
					strobe = 1'b1; last = 1'b1;
					out_port = gword_q[20] ? gword_q[19:16] : 4'd0;
					status = gword_q[20] ? ST_FORWARD : ST_DROP;
					state_d = FS_IDLE;
				end else if (hit_q) begin
					strobe = 1'b1; last = 1'b1;
					out_port = hit_port_q;
					state_d = FS_IDLE;
				end else if (mac_q[40]) begin
					state_d = FS_FLOOD;
				end else begin
					strobe = 1'b1; last = 1'b1;
					if (vword_q[20]) begin
						out_port = vword_q[19:16];
					end else if (gword_q[20]) begin
						out_port = gword_q[19:16];
					end else begin
						status = ST_DROP;
					end
					state_d = FS_IDLE;
				end
			end
			FS_FLOOD: begin
				strobe  = 1'b1;
				flooded = 1'b1;
				if (fl_any) begin
					out_port = fl_next[3:0];
					last     = !fl_more && !flood_gdef_q;
					if (last) state_d = FS_IDLE;
				end else begin
					out_port = gword_q[19:16];
					last     = 1'b1;
					state_d  = FS_IDLE;
				end
			end
			FS_VWR: begin
				strobe = 1'b1;
				last   = 1'b1;
				status = ST_REGISTERED;
				if (reg_ok) begin
					v_we = 1'b1;
					v_wdata = vword_q | VW'(21'd1 << port_q);
					if (mac_q == DefaultMarker) begin
						v_wdata[20:16] = {1'b1, port_q};
					end else if (hit_q) begin
						e_we = 1'b1;
						e_waddr = hit_idx_q;
					end else if (count_q < TABLE_ENTRIES) begin
						e_we = 1'b1;
					end else begin
						status = ST_FULL;
					end
				end
				state_d = FS_IDLE;
			end
			FS_CLEAR: begin
				v_we    = 1'b1;
				v_waddr = clr_q[VAW-1:0];
				v_wdata = '0;
				if (clr_q == (VAW+1)'(VLANS - 1)) begin
					state_d = FS_IDLE;
					if (op_q == OP_CLEAR) begin
						strobe = 1'b1; last = 1'b1;
						status = ST_CLEARED;
					end
				end
			end
			default: state_d = FS_IDLE;
		endcase
	end
endmodule

>>> rtl/core/vmpc_ram.sv
module vmpc_ram #(
	parameter int Width = 8,
	parameter int Depth = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(Depth)-1:0] waddr,
	input  logic [Width-1:0]         wdata,
	input  logic [$clog2(Depth)-1:0] raddr,
	output logic [Width-1:0]         rdata
);
	logic [Width-1:0] mem [Depth];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

>>> test/vlan_mac_port_classifier_test.sv
module vlan_mac_port_classifier_test
	import vmpc_pkg::*;
();

	timeunit 1ns;
	timeprecision 1ps;

	// table geometry seen by the block at its defaults
	localparam int NumEntries = TableEntriesDef;
	localparam int NumPorts   = PortsDef;
	localparam int NumVlans   = VlansDef;
	localparam int MaxHits    = 16;
	// settle margin covers a sweep after reset or clear and a scan of the whole table
	localparam int SettleCycles = NumVlans + NumEntries + 64;
	localparam longint CycleLimit = 2_000_000;

	// one input transaction, all fields kept side by side
	typedef struct packed {
		op_t         op;
		logic [15:0] eth_type;
		logic [15:0] tag_ctrl;
		logic [47:0] dest_mac;
		logic [3:0]  port_index;
		logic [11:0] entry_vid;
		logic [47:0] entry_mac;
	} frame_cmd_t;

	// one expected result
	typedef struct packed {
		logic [3:0] out_port;
		status_t    status;
		logic       flooded;
		logic       last;
	} port_result_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic        busy;
	logic [1:0]  op = OP_CLASSIFY;
	logic [15:0] eth_type = '0;
	logic [15:0] tag_ctrl = '0;
	logic [47:0] dest_mac = '0;
	logic [3:0]  port_index = '0;
	logic [11:0] entry_vid = '0;
	logic [47:0] entry_mac = '0;
	logic        strobe;
	logic [3:0]  out_port;
	logic [2:0]  status;
	logic        flooded;
	logic        last;

	vlan_mac_port_classifier DUT (
		.clk, .arst_n, .start, .busy, .op, .eth_type, .tag_ctrl, .dest_mac,
		.port_index, .entry_vid, .entry_mac, .strobe, .out_port, .status,
		.flooded, .last
	);

	always #1 clk = ~clk;

	// predictor's own copy of the lookup stores
	logic [59:0] fwd_keys [NumEntries];
	logic [3:0]  fwd_ports [NumEntries];
	logic        fwd_valid [NumEntries];
	int          fwd_fill;
	logic [15:0] vid_members [NumVlans];
	logic [4:0]  vid_default [NumVlans];

	frame_cmd_t   pending_cmds [$];
	port_result_t expected_ports [$];
	int           mismatches = 0;
	longint       cycle_count = 0;

	function automatic void wipe_tables();
		for (int i = 0; i < NumEntries; i++) fwd_valid[i] = 1'b0;
		fwd_fill = 0;
		for (int v = 0; v < NumVlans; v++) begin
			vid_members[v] = '0;
			vid_default[v] = '0;
		end
	endfunction

	function automatic int find_entry(logic [59:0] key);
		for (int i = 0; i < NumEntries; i++)
			if (fwd_valid[i] && fwd_keys[i] == key) return i;
		return -1;
	endfunction

	function automatic void push_port(logic [3:0] p, status_t s, logic fl);
		port_result_t r;
		r.out_port = p;
		r.status   = s;
		r.flooded  = fl;
		r.last     = 1'b0;
		expected_ports.push_back(r);
	endfunction

	// work out the results of one accepted transaction and update the stores
	function automatic void predict_ports(frame_cmd_t c);
		logic [11:0] vid;
		logic [4:0]  gdef;
		logic [4:0]  vdef;
		logic [15:0] members;
		int          hit;
		int          n;
		int          before_cnt;
		status_t     st;
		before_cnt = expected_ports.size();
		case (c.op)
			OP_CLASSIFY: begin
				vid = (c.eth_type == TpidVlan) ? c.tag_ctrl[11:0] : UntaggedVid;
				gdef = vid_default[UntaggedVid];
				members = vid_members[vid];
				hit = find_entry({vid, c.dest_mac});
				if (members == '0) begin
					if (gdef[4]) push_port(gdef[3:0], ST_FORWARD, 1'b0);
					else push_port('0, ST_DROP, 1'b0);
				end else if (hit >= 0) begin
					push_port(fwd_ports[hit], ST_FORWARD, 1'b0);
				end else if (c.dest_mac[40]) begin
					// flood: members in ascending order, then untagged default
					n = 0;
					for (int p = 0; p < NumPorts; p++)
						if (members[p]) begin
							push_port(p[3:0], ST_FORWARD, 1'b1);
							n++;
						end
					if (gdef[4] && vid != UntaggedVid && n < MaxHits)
						push_port(gdef[3:0], ST_FORWARD, 1'b1);
				end else begin
					vdef = vid_default[vid];
					if (vdef[4]) push_port(vdef[3:0], ST_FORWARD, 1'b0);
					else if (gdef[4]) push_port(gdef[3:0], ST_FORWARD, 1'b0);
					else push_port('0, ST_DROP, 1'b0);
				end
			end
			OP_REGISTER: begin
				st = ST_REGISTERED;
				if (c.entry_mac != '0 && int'(c.port_index) < NumPorts) begin
					vid_members[c.entry_vid][c.port_index] = 1'b1;
					if (c.entry_mac == DefaultMarker) begin
						vid_default[c.entry_vid] = {1'b1, c.port_index};
					end else begin
						hit = find_entry({c.entry_vid, c.entry_mac});
						if (hit >= 0) begin
							fwd_ports[hit] = c.port_index;
						end else if (fwd_fill < NumEntries) begin
							fwd_keys[fwd_fill]  = {c.entry_vid, c.entry_mac};
							fwd_ports[fwd_fill] = c.port_index;
							fwd_valid[fwd_fill] = 1'b1;
							fwd_fill++;
						end else begin
							st = ST_FULL;
						end
					end
				end
				push_port('0, st, 1'b0);
			end
			OP_CLEAR: begin
				wipe_tables();
				push_port('0, ST_CLEARED, 1'b0);
			end
			default: ;
		endcase
		if (expected_ports.size() > before_cnt)
			expected_ports[expected_ports.size() - 1].last = 1'b1;
	endfunction

	// stimulus builders
	function automatic frame_cmd_t rand_cmd();
		frame_cmd_t c;
		c.op         = OP_CLASSIFY;
		c.eth_type   = 16'($urandom);
		c.tag_ctrl   = 16'($urandom);
		c.dest_mac   = {16'($urandom), 32'($urandom)};
		c.port_index = 4'($urandom);
		c.entry_vid  = 12'($urandom);
		c.entry_mac  = {16'($urandom), 32'($urandom)};
		return c;
	endfunction

	function automatic frame_cmd_t reg_cmd(logic [3:0] p, logic [11:0] v, logic [47:0] m);
		frame_cmd_t c;
		c = rand_cmd();
		c.op = OP_REGISTER;
		c.port_index = p;
		c.entry_vid = v;
		c.entry_mac = m;
		return c;
	endfunction

	function automatic frame_cmd_t cls_cmd(logic tagged_frm, logic [11:0] v, logic [47:0] m);
		frame_cmd_t c;
		c = rand_cmd();
		c.op = OP_CLASSIFY;
		if (tagged_frm) begin
			c.eth_type = TpidVlan;
			c.tag_ctrl[11:0] = v;
		end else if (c.eth_type == TpidVlan) begin
			c.eth_type = 16'h0800;
		end
		c.dest_mac = m;
		return c;
	endfunction

	// driver: one transaction at a time, random gap before each
	int gap_left = 0;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start <= 1'b0;
			gap_left <= 0;
		end else begin
			cycle_count <= cycle_count + 1;
			if (start && !busy) begin
				predict_ports(pending_cmds.pop_front());
				start <= 1'b0;
				gap_left <= $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 15);
			end else if (!start) begin
				if (gap_left > 0) begin
					gap_left <= gap_left - 1;
				end else if (pending_cmds.size() > 0) begin
					start      <= 1'b1;
					op         <= pending_cmds[0].op;
					eth_type   <= pending_cmds[0].eth_type;
					tag_ctrl   <= pending_cmds[0].tag_ctrl;
					dest_mac   <= pending_cmds[0].dest_mac;
					port_index <= pending_cmds[0].port_index;
					entry_vid  <= pending_cmds[0].entry_vid;
					entry_mac  <= pending_cmds[0].entry_mac;
				end
			end
		end
	end

	// monitor: every strobe is checked against the oldest expectation
	always @(posedge clk) begin
		port_result_t want;
		if (arst_n && strobe) begin
			if (expected_ports.size() == 0) begin
				mismatches <= mismatches + 1;
				if (mismatches < 10)
					$display("unexpected result: port %0d status %0d flooded %0b last %0b",
						out_port, status, flooded, last);
			end else begin
				want = expected_ports.pop_front();
				if (out_port !== want.out_port || status !== want.status ||
					flooded !== want.flooded || last !== want.last) begin
					mismatches <= mismatches + 1;
					if (mismatches < 10)
						$display("mismatch: exp port %0d st %0d fl %0b last %0b, got %0d %0d %0b %0b",
							want.out_port, want.status, want.flooded, want.last,
							out_port, status, flooded, last);
				end
			end
		end
	end

	// timeout guard
	always @(posedge clk) begin
		if (cycle_count > CycleLimit) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	task automatic wait_drained();
		while (pending_cmds.size() > 0 || start || busy || expected_ports.size() > 0)
			@(posedge clk);
	endtask

	initial begin
		logic [11:0] vids [4];
		logic [47:0] macs [8];
		int          pick;
		int          rnd;
		frame_cmd_t  c;
		wipe_tables();
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// directed: drop with nothing set up, skip cases, defaults, hits, floods
		pending_cmds.push_back(cls_cmd(1'b0, '0, 48'h0000_1111_2222));
		pending_cmds.push_back(cls_cmd(1'b1, 12'h005, 48'hffff_ffff_ffff));
		pending_cmds.push_back(reg_cmd(4'd3, 12'h005, 48'h0));           // zero MAC skip
		pending_cmds.push_back(reg_cmd(4'd15, UntaggedVid, DefaultMarker)); // untagged default
		pending_cmds.push_back(cls_cmd(1'b1, 12'h777, 48'h0000_0000_0001)); // unknown VLAN
		pending_cmds.push_back(reg_cmd(4'd0, 12'h000, 48'hffff_ffff_fffe));
		pending_cmds.push_back(reg_cmd(4'd7, 12'h000, 48'h0000_0000_0001));
		pending_cmds.push_back(reg_cmd(4'd9, 12'h000, 48'h0000_0000_0001)); // overwrite
		pending_cmds.push_back(cls_cmd(1'b1, 12'h000, 48'h0000_0000_0001));  // hit
		pending_cmds.push_back(cls_cmd(1'b1, 12'h000, 48'h0100_0000_0005));  // flood + gdef
		pending_cmds.push_back(cls_cmd(1'b1, 12'h000, 48'h0000_0000_0005));  // unicast miss
		pending_cmds.push_back(reg_cmd(4'd2, 12'h000, DefaultMarker));
		pending_cmds.push_back(cls_cmd(1'b1, 12'h000, 48'h0000_0000_0005));  // vlan default
		for (int p = 0; p < 16; p++)
			pending_cmds.push_back(reg_cmd(p[3:0], 12'hfff, 48'h0100_0000_00aa));
		pending_cmds.push_back(cls_cmd(1'b0, '0, 48'h0100_0000_0bbb)); // full flood, untagged
		c = cls_cmd(1'b0, '0, 48'h0000_0000_0001);
		c.op = OP_NONE;                                                 // unknown op
		pending_cmds.push_back(c);
		pending_cmds.push_back(cls_cmd(1'b1, 12'h000, 48'h0000_0000_0001));

		// pause until everything has come back
		wait_drained();

		// fill the table to overflow, then clear
		for (int i = 0; i < NumEntries + 3; i++)
			pending_cmds.push_back(reg_cmd(4'($urandom), 12'($urandom_range(0, 2)),
				{16'h0000, 32'(i + 100)}));
		pending_cmds.push_back(cls_cmd(1'b1, 12'h001, 48'h0100_0000_0000));
		c = rand_cmd();
		c.op = OP_CLEAR;
		pending_cmds.push_back(c);
		wait_drained();

		// random: small working set of VLANs and MACs so lookups hit
		for (int i = 0; i < 4; i++) vids[i] = 12'($urandom);
		vids[3] = UntaggedVid;
		for (int i = 0; i < 8; i++) macs[i] = {16'($urandom), 32'($urandom)};
		macs[7] = '1;
		for (int i = 0; i < 55; i++) begin
			rnd = $urandom_range(0, 99);
			pick = $urandom_range(0, 7);
			if (rnd < 35)
				c = reg_cmd(4'($urandom), vids[$urandom_range(0, 3)],
					($urandom_range(0, 5) == 0) ? DefaultMarker :
					($urandom_range(0, 9) == 0) ? 48'h0 : macs[pick]);
			else if (rnd < 80)
				c = cls_cmd(1'b1, vids[$urandom_range(0, 3)],
					($urandom_range(0, 3) == 0) ? (macs[pick] | 48'h0100_0000_0000)
						: macs[pick]);
			else if (rnd < 95)
				c = rand_cmd();
			else if (rnd < 98) begin
				c = rand_cmd();
				c.op = OP_NONE;
			end else begin
				c = rand_cmd();
				c.op = OP_CLEAR;
			end
			pending_cmds.push_back(c);
		end
		wait_drained();
		repeat (SettleCycles) @(posedge clk);
		if (mismatches == 0 && expected_ports.size() == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
